[hw/rtl/isl_pkg.sv]
// ----------------------------------------------------------------------------
// isl_pkg: shared definitions for the indexed shift list
// Request modes, status codes, cell commands and the read tree sizing.
// ----------------------------------------------------------------------------
package isl_pkg;

	localparam int DATA_W       = 64;
	localparam int POS_W        = 7;
	localparam int CNT_OUT_W    = 7;
	localparam int CAPACITY_DEF = 64;
	localparam int TREE_FAN     = 4;

	// Request modes carried on the mode field.
	typedef enum logic [2:0] {
		MODE_READ   = 3'd0,
		MODE_WRITE  = 3'd1,
		MODE_APPEND = 3'd2,
		MODE_INSERT = 3'd3,
		MODE_REMOVE = 3'd4,
		MODE_CLEAR  = 3'd5
	} mode_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Update applied by every cell in the chain.
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_WRITE  = 2'd1,
		CELL_INSERT = 2'd2,
		CELL_REMOVE = 2'd3
	} cell_op_t;

	// Command broadcast from the controller to the chain.
	typedef struct packed {
		cell_op_t op;
		logic     rd;
	} cell_cmd_t;

	// Number of registered levels in the read tree for a given cell count.
	function automatic int tree_levels(input int cap);
		int lvl;
		int span;
		lvl  = 0;
		span = 1;
		while (span < cap) begin
			span = span * TREE_FAN;
			lvl  = lvl + 1;
		end
		return lvl;
	endfunction

endpackage

[hw/rtl/isl_cell.sv]
// ----------------------------------------------------------------------------
// isl_cell: one entry of the shift list
// Holds one word, compares its own index with the target and loads the new
// word or a neighbor's word; drives its word to the read tree on a hit.
// ----------------------------------------------------------------------------
module isl_cell
	import isl_pkg::*;
#(
	parameter int INDEX = 0,
	parameter int CW    = POS_W
) (
	input  logic              clk,
	input  cell_cmd_t         cmd,
	input  logic [CW-1:0]     tgt,
	input  logic [DATA_W-1:0] word_in,
	input  logic [DATA_W-1:0] left,
	input  logic [DATA_W-1:0] right,
	output logic [DATA_W-1:0] stored,
	output logic [DATA_W-1:0] leaf
);

	localparam logic [CW-1:0] MY_IDX = CW'(INDEX);

	logic [DATA_W-1:0] word_q;

	// Entry update: insert pulls from the lower neighbor, remove from the upper one.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			CELL_HOLD: begin
			end
			CELL_WRITE: begin
				if (MY_IDX == tgt) word_q <= word_in;
			end
			CELL_INSERT: begin
				if (MY_IDX == tgt) word_q <= word_in;
				else if (MY_IDX > tgt) word_q <= left;
			end
			CELL_REMOVE: begin
				if (MY_IDX >= tgt) word_q <= right;
			end
		endcase
	end

	assign stored = word_q;

	// Only the addressed cell puts its word on the read tree.
	assign leaf = (cmd.rd && (MY_IDX == tgt)) ? word_q : '0;

endmodule

[hw/rtl/isl_read_tree.sv]
// ----------------------------------------------------------------------------
// isl_read_tree: registered OR tree over the cell outputs
// At most one leaf is nonzero, so an OR reduction selects the read word.
// Every level is registered, from the leaves up to the root.
// ----------------------------------------------------------------------------
module isl_read_tree
	import isl_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int LVLS     = tree_levels(CAPACITY)
) (
	input  logic                             clk,
	input  logic [CAPACITY-1:0][DATA_W-1:0] leaf,
	output logic [DATA_W-1:0]                root
);

	wire [LVLS:0][CAPACITY-1:0][DATA_W-1:0] lvl;

	assign lvl[0] = leaf;

	for (genvar l = 0; l < LVLS; l++) begin : g_lvl
		for (genvar j = 0; j < CAPACITY; j++) begin : g_slot
			if (j * (TREE_FAN ** (l + 1)) < CAPACITY) begin : g_node
				wire  [TREE_FAN-1:0][DATA_W-1:0] ch;
				logic [DATA_W-1:0]               sum;
				logic [DATA_W-1:0]               node_q;

				// Gather the children that exist at the level below.
				for (genvar k = 0; k < TREE_FAN; k++) begin : g_ch
					if (j * TREE_FAN + k < CAPACITY) begin : g_in
						assign ch[k] = lvl[l][j * TREE_FAN + k];
					end else begin : g_zero
						assign ch[k] = '0;
					end
				end

				always_comb begin
					sum = '0;
					for (int k = 0; k < TREE_FAN; k++) begin
						sum = sum | ch[k];
					end
				end

				always_ff @(posedge clk) begin
					node_q <= sum;
				end

				assign lvl[l + 1][j] = node_q;
			end else begin : g_empty
				assign lvl[l + 1][j] = '0;
			end
		end
	end

	assign root = lvl[LVLS][0];

endmodule

[hw/rtl/indexed_shift_list_unit.sv]
// ----------------------------------------------------------------------------
// indexed_shift_list_unit: ordered list of 64-bit words held in a cell chain
// A transfer starts the chain update; the result enters the output register once the
// read tree has drained, where LVLS = ceil(log4(CAPACITY)) is the tree's depth.
// A new request is stalled until the last one has entered the output register, and a
// stalled output holds that register and the request in flight; every shift is
// applied by all cells at once. Reset clears the entry count and the handshake state;
// cell contents are left undefined until written.
// ----------------------------------------------------------------------------
module indexed_shift_list_unit
	import isl_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        mode,
	input  logic [POS_W-1:0]  position,
	input  logic [DATA_W-1:0] word_in,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [DATA_W-1:0] word_out,
	output logic [CNT_OUT_W-1:0] count,
	output logic              is_empty,
	output logic [1:0]        status
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CW    = (POS_W > CNT_W) ? POS_W : CNT_W;
	localparam int LVLS  = tree_levels(CAPACITY);
	localparam int LAT_W = $clog2(LVLS + 1);
	localparam logic [CW-1:0]    CAP_X    = CW'(CAPACITY);
	localparam logic [LAT_W-1:0] LAT_LAST = LAT_W'(LVLS);

	// Request and control registers.
	logic              busy_q;
	logic [LAT_W-1:0]  lat_q;
	logic [2:0]        req_mode_q;
	logic [CW-1:0]     req_pos_q;
	logic [DATA_W-1:0] req_word_q;
	logic [CW-1:0]     count_q;

	// Result fields waiting for the read tree.
	logic [CNT_OUT_W-1:0] res_count_q;
	logic                 res_empty_q;
	status_t              res_status_q;

	// Output register.
	logic                 out_valid_q;
	logic [DATA_W-1:0]    out_word_q;
	logic [CNT_OUT_W-1:0] out_count_q;
	logic                 out_empty_q;
	status_t              out_status_q;

	// Controller decisions.
	cell_op_t          op_c;
	logic              rd_c;
	logic [CW-1:0]     tgt_c;
	logic [CW-1:0]     cnt_nx;
	status_t           st_c;
	logic              first_c;
	logic              done_c;
	logic              load_c;
	logic              accept_c;
	cell_cmd_t         cmd;

	wire  [CAPACITY-1:0][DATA_W-1:0] stored;
	wire  [CAPACITY-1:0][DATA_W-1:0] leaf;
	logic [DATA_W-1:0]               root;

	// Decode the request against the current entry count.
	always_comb begin
		op_c   = CELL_HOLD;
		rd_c   = 1'b0;
		tgt_c  = req_pos_q;
		cnt_nx = count_q;
		st_c   = ST_OK;
		unique case (req_mode_q)
			MODE_READ: begin
				if (req_pos_q < count_q) rd_c = 1'b1;
				else st_c = ST_RANGE;
			end
			MODE_WRITE: begin
				if (req_pos_q < count_q) op_c = CELL_WRITE;
				else st_c = ST_RANGE;
			end
			MODE_APPEND: begin
				if (count_q == CAP_X) begin
					st_c = ST_FULL;
				end else begin
					op_c   = CELL_WRITE;
					tgt_c  = count_q;
					cnt_nx = count_q + CW'(1);
				end
			end
			MODE_INSERT: begin
				if (req_pos_q > count_q) begin
					st_c = ST_RANGE;
				end else if (count_q == CAP_X) begin
					st_c = ST_FULL;
				end else begin
					op_c   = CELL_INSERT;
					cnt_nx = count_q + CW'(1);
				end
			end
			MODE_REMOVE: begin
				if (req_pos_q >= count_q) begin
					st_c = ST_RANGE;
				end else begin
					op_c   = CELL_REMOVE;
					cnt_nx = count_q - CW'(1);
				end
			end
			MODE_CLEAR: begin
				cnt_nx = '0;
			end
			default: begin
			end
		endcase
	end

	// Sequencing: the chain updates once, then the read tree drains.
	assign first_c  = busy_q && (lat_q == '0);
	assign done_c   = busy_q && (lat_q == LAT_LAST);
	assign load_c   = done_c && (!out_valid_q || !out_stall);
	assign accept_c = in_valid && !busy_q;
	assign in_stall = busy_q;

	assign cmd = '{op: (first_c ? op_c : CELL_HOLD), rd: (busy_q && rd_c)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			lat_q   <= '0;
			count_q <= '0;
		end else begin
			if (accept_c) begin
				busy_q <= 1'b1;
				lat_q  <= '0;
			end else if (load_c) begin
				busy_q <= 1'b0;
			end else if (busy_q && !done_c) begin
				lat_q <= lat_q + LAT_W'(1);
			end
			if (first_c) count_q <= cnt_nx;
		end
	end

	// Request capture and result fields.
	always_ff @(posedge clk) begin
		if (accept_c) begin
			req_mode_q <= mode;
			req_pos_q  <= CW'(position);
			req_word_q <= word_in;
		end
		if (first_c) begin
			res_count_q  <= cnt_nx[CNT_OUT_W-1:0];
			res_empty_q  <= (cnt_nx == '0);
			res_status_q <= st_c;
		end
	end

	// Chain of cells; each end feeds itself in place of a missing neighbor.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam int LI = (i == 0) ? 0 : i - 1;
		localparam int RI = (i == CAPACITY - 1) ? i : i + 1;

		isl_cell #(
			.INDEX (i),
			.CW    (CW)
		) u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.tgt     (tgt_c),
			.word_in (req_word_q),
			.left    (stored[LI]),
			.right   (stored[RI]),
			.stored  (stored[i]),
			.leaf    (leaf[i])
		);
	end

	isl_read_tree #(
		.CAPACITY (CAPACITY),
		.LVLS     (LVLS)
	) u_read_tree (
		.clk  (clk),
		.leaf (leaf),
		.root (root)
	);

	// Output register: the last result waits here while the next request transfers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_c) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_c) begin
			out_word_q   <= root;
			out_count_q  <= res_count_q;
			out_empty_q  <= res_empty_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign word_out  = out_word_q;
	assign count     = out_count_q;
	assign is_empty  = out_empty_q;
	assign status    = out_status_q;

`ifndef SYNTH
	// The entry count never exceeds the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_X)
		else $error("entry count above capacity");

	// The count only moves in the first cycle of a request.
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && (lat_q != '0)) |=> $stable(count_q))
		else $error("entry count changed while the read tree drained");

	// A full status is only reported with every cell in use.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(load_c && (res_status_q == ST_FULL)) |-> (count_q == CAP_X))
		else $error("full status with free cells");

	// A result appears only after the read tree has drained.
	a_result_timing: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(done_c))
		else $error("result loaded before the read tree finished");
`endif

endmodule
